// ----- rtl/mkga_pkg.sv -----
package mkga_pkg;

	localparam int SLOTS       = 8;
	localparam int KEY_WIDTH   = 64;
	localparam int COUNT_WIDTH = 32;
	localparam int GROUPS      = 8;
	localparam int TMO_WIDTH   = 32;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BIT_CNT_W = $clog2(KEY_WIDTH);
	localparam int CMP_W = (COUNT_WIDTH > TMO_WIDTH) ? COUNT_WIDTH : TMO_WIDTH;

	// 600 s at 100 ticks per second.
	localparam logic [TMO_WIDTH-1:0] TMO_RESET = TMO_WIDTH'(600 * 100);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		MODE_KEY   = 3'd0,
		MODE_TICK  = 3'd1,
		MODE_TEMP  = 3'd2,
		MODE_AUTH  = 3'd3,
		MODE_CLEAR = 3'd4,
		MODE_LOAD  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		UNLOCK_NORMAL = 2'd0,
		UNLOCK_TEMP   = 2'd1,
		UNLOCK_AUTHZ  = 2'd2
	} unlock_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic load;
	} ring_ctl_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic              slot_ok;
		logic [SLOT_W-1:0] slot;
		logic [GROUPS-1:0] groups;
	} req_t;

	typedef struct packed {
		logic              authorized;
		logic              matched;
		logic [2:0]        matched_slot;
		logic              half_unlock;
		logic              need_more;
		logic [GROUPS-1:0] candidate_groups;
		logic [1:0]        unlock_kind;
		logic              log_event;
	} res_t;

endpackage

// ----- rtl/mkga_keyring.sv -----
module mkga_keyring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mkga_pkg::ring_ctl_t           ctl,
	input  logic [mkga_pkg::SLOT_W-1:0]   load_slot,
	input  logic [mkga_pkg::KEY_WIDTH-1:0] key,
	output logic [mkga_pkg::SLOTS-1:0]    match
);
	import mkga_pkg::*;

	logic [KEY_WIDTH-1:0] slot_key_q [SLOTS];
	logic [KEY_WIDTH-1:0] pkey_q;
	logic [SLOTS-1:0]     miss_q;

	// Every slot key rotates one bit per step, so after a full compare the
	// keys are back in their stored alignment and a load can write them whole.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				slot_key_q[s] <= '0;
			end
			miss_q <= '0;
		end else begin
			for (int s = 0; s < SLOTS; s++) begin
				if (ctl.load && load_slot == SLOT_W'(s)) begin
					slot_key_q[s] <= key;
				end else if (ctl.step) begin
					slot_key_q[s] <= {slot_key_q[s][0], slot_key_q[s][KEY_WIDTH-1:1]};
				end
			end
			if (ctl.start) begin
				miss_q <= '0;
			end else if (ctl.step) begin
				for (int s = 0; s < SLOTS; s++) begin
					miss_q[s] <= miss_q[s] | (slot_key_q[s][0] ^ pkey_q[0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			pkey_q <= key;
		end else if (ctl.step) begin
			pkey_q <= {1'b0, pkey_q[KEY_WIDTH-1:1]};
		end
	end

	assign match = ~miss_q;

endmodule

// ----- rtl/mkga_state.sv -----
module mkga_state (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mkga_pkg::TMO_WIDTH-1:0] cfg_wdata,
	input  logic                          apply,
	input  mkga_pkg::req_t                req,
	input  logic [mkga_pkg::SLOTS-1:0]    match,
	output mkga_pkg::res_t                res
);
	import mkga_pkg::*;

	logic [GROUPS-1:0]      grp_q [SLOTS];
	logic [GROUPS-1:0]      grp_n [SLOTS];
	logic [GROUPS-1:0]      cand_q, cand_n;
	logic [SLOTS-1:0]       chk_q, chk_n;
	logic [1:0]             um_q, um_n;
	logic [COUNT_WIDTH-1:0] idle_q, idle_n, idle_inc;
	logic [TMO_WIDTH-1:0]   tmo_q;
	logic [SLOT_W-1:0]      msl;
	logic                   any_match;
	logic                   auth;
	logic                   log_ev;
	logic                   need;

	// Lowest matching slot wins.
	always_comb begin
		msl = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (match[s]) begin
				msl = SLOT_W'(s);
			end
		end
	end

	assign any_match = |match;
	assign idle_inc = (idle_q == COUNT_MAX) ? idle_q : idle_q + COUNT_WIDTH'(1);

	always_comb begin
		cand_n = cand_q;
		chk_n  = chk_q;
		um_n   = um_q;
		idle_n = idle_q;
		auth   = 1'b0;
		log_ev = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			grp_n[s] = grp_q[s];
		end
		unique case (req.mode)
			MODE_KEY: begin
				if (any_match) begin
					cand_n = cand_q & grp_q[msl];
					if (cand_n != '0) begin
						auth = 1'b1;
						chk_n[msl] = 1'b1;
						idle_n = '0;
					end
				end
			end
			MODE_TICK: begin
				idle_n = idle_inc;
				if (CMP_W'(idle_inc) > CMP_W'(tmo_q)) begin
					cand_n = '1;
					chk_n  = '0;
					um_n   = UNLOCK_NORMAL;
				end
			end
			MODE_TEMP: begin
				um_n   = UNLOCK_TEMP;
				idle_n = '0;
				log_ev = 1'b1;
			end
			MODE_AUTH: begin
				um_n   = UNLOCK_AUTHZ;
				log_ev = 1'b1;
			end
			MODE_CLEAR: begin
				cand_n = '1;
				chk_n  = '0;
				um_n   = UNLOCK_NORMAL;
			end
			MODE_LOAD: begin
				if (req.slot_ok) begin
					for (int s = 0; s < SLOTS; s++) begin
						if (req.slot == SLOT_W'(s)) begin
							grp_n[s] = req.groups;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// A candidate group still needs a key while one of its members has not been checked, unless a temporary unlock holds.
	always_comb begin
		need = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (!chk_n[s] && (grp_n[s] & cand_n) != '0) begin
				need = 1'b1;
			end
		end
		if (um_n == UNLOCK_TEMP) begin
			need = 1'b0;
		end
	end

	always_comb begin
		res.authorized       = auth;
		res.matched          = (req.mode == MODE_KEY) && any_match;
		res.matched_slot     = (req.mode == MODE_KEY) ? 3'(msl) : 3'd0;
		res.half_unlock      = (chk_n != '0);
		res.need_more        = need;
		res.candidate_groups = cand_n;
		res.unlock_kind      = um_n;
		res.log_event        = log_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				grp_q[s] <= '0;
			end
			cand_q <= '1;
			chk_q  <= '0;
			um_q   <= UNLOCK_NORMAL;
			idle_q <= '0;
			tmo_q  <= TMO_RESET;
		end else begin
			if (cfg_we) begin
				tmo_q <= cfg_wdata;
			end
			if (apply) begin
				for (int s = 0; s < SLOTS; s++) begin
					grp_q[s] <= grp_n[s];
				end
				cand_q <= cand_n;
				chk_q  <= chk_n;
				um_q   <= um_n;
				idle_q <= idle_n;
			end
		end
	end

endmodule

// ----- rtl/multi_key_group_authorizer.sv -----
// Key slot authorizer. Each request takes one of six modes; a present-key
// request compares the key with all slots one bit per cycle in the compare
// state before its result is registered, while every other mode goes from
// idle straight to the done state. One request is in work at a time, and a
// new request is accepted as soon as the previous result sits in the output
// register, even if that result is still stalled. Loads write a slot key and
// group mask whole; the idle timeout register may be written while idle and
// resets to 60000 ticks.
module multi_key_group_authorizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [63:0] key,
	input  logic [2:0]  slot,
	input  logic [7:0]  slot_groups,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        authorized,
	output logic        matched,
	output logic [2:0]  matched_slot,
	output logic        half_unlock,
	output logic        need_more,
	output logic [7:0]  candidate_groups,
	output logic [1:0]  unlock_kind,
	output logic        log_event
);
	import mkga_pkg::*;

	state_t               state_q, state_n;
	logic [BIT_CNT_W-1:0] cnt_q;
	req_t                 req_q, req_in;
	ring_ctl_t            ctl;
	logic [SLOTS-1:0]     match;
	res_t                 res, res_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 out_free;
	logic                 apply;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		req_in.mode    = mode;
		req_in.slot_ok = (32'(slot) < 32'(SLOTS));
		req_in.slot    = SLOT_W'(slot);
		req_in.groups  = slot_groups;
	end

	always_comb begin
		state_n   = state_q;
		ctl.start = 1'b0;
		ctl.step  = 1'b0;
		ctl.load  = 1'b0;
		apply     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.start = (mode == MODE_KEY);
					ctl.load  = (mode == MODE_LOAD) && req_in.slot_ok;
					state_n   = (mode == MODE_KEY) ? ST_CMP : ST_DONE;
				end
			end
			ST_CMP: begin
				ctl.step = 1'b1;
				if (cnt_q == '0) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					apply   = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				cnt_q <= BIT_CNT_W'(KEY_WIDTH - 1);
			end else if (ctl.step) begin
				cnt_q <= cnt_q - BIT_CNT_W'(1);
			end
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
		end
		if (apply) begin
			res_q <= res;
		end
	end

	mkga_keyring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.load_slot (req_in.slot),
		.key       (key[KEY_WIDTH-1:0]),
		.match     (match)
	);

	mkga_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.apply     (apply),
		.req       (req_q),
		.match     (match),
		.res       (res)
	);

	assign out_valid        = out_valid_q;
	assign authorized       = res_q.authorized;
	assign matched          = res_q.matched;
	assign matched_slot     = res_q.matched_slot;
	assign half_unlock      = res_q.half_unlock;
	assign need_more        = res_q.need_more;
	assign candidate_groups = res_q.candidate_groups;
	assign unlock_kind      = res_q.unlock_kind;
	assign log_event        = res_q.log_event;

`ifndef NO_ASSERTIONS
	a_key_goes_serial: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_KEY |=> state_q == ST_CMP)
		else $error("key request did not start the serial compare");

	a_cmp_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP && cnt_q == '0 |=> state_q == ST_DONE)
		else $error("serial compare did not finish after the last bit");

	a_auth_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && authorized |-> matched && half_unlock)
		else $error("authorized result without a match or checked slot");
`endif

endmodule
